// ----- src/minkowski_distance_accumulator_assert.svh -----
// assertion macros for the minkowski distance accumulator checker
// no dependencies
`ifndef MINKOWSKI_DISTANCE_ACCUMULATOR_ASSERT_SVH
`define MINKOWSKI_DISTANCE_ACCUMULATOR_ASSERT_SVH

// property checked while out of reset
`define MDA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define MDA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/mda_pkg.sv -----
// shared types and constants of the minkowski distance accumulator
// no dependencies
package mda_pkg;

   localparam int MODE_W = 3;
   localparam int DIST_W = 32;
   localparam int ACC_W  = 64;
   localparam int MUL_W  = 32;
   localparam int BIT_W  = 5;

   localparam logic [MODE_W-1:0] MODE_ZERO = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ONE  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TWO  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_P3   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_P4   = 3'd4;

   // highest root bit that can pass for each exponent
   localparam logic [BIT_W-1:0] ROOT2_TOP = 5'd31;
   localparam logic [BIT_W-1:0] ROOT3_TOP = 5'd21;
   localparam logic [BIT_W-1:0] ROOT4_TOP = 5'd15;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_TERM = 5'b00010,
      ST_ACC  = 5'b00100,
      ST_ROOT = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

endpackage

// ----- src/mda_channels.sv -----
// request and response channel interfaces of the minkowski distance accumulator
// depends on mda_pkg
interface mda_req_if #(parameter int ELEM_BITS = 12);
   logic                        valid;
   logic                        ready;
   logic signed [ELEM_BITS-1:0] elem_a;
   logic signed [ELEM_BITS-1:0] elem_b;
   logic                        last_element;

   modport source (output valid, output elem_a, output elem_b, output last_element,
                   input ready);
   modport sink   (input valid, input elem_a, input elem_b, input last_element,
                   output ready);
endinterface

interface mda_rsp_if;
   import mda_pkg::*;
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance;
   logic              saturated;

   modport source (output valid, output distance, output saturated, input ready);
   modport sink   (input valid, input distance, input saturated, output ready);
endinterface

// ----- src/minkowski_distance_accumulator.sv -----
// minkowski distance accumulator top level: shared multiplier under a sequencer
// depends on mda_pkg and mda_channels
//
// channel  | direction | contents
// req_ch   | in        | elem_a, elem_b, last_element (valid/ready)
// rsp_ch   | out       | distance, saturated (valid/ready, registered)
// csr_*    | in        | norm_mode write, no read-back
//
// p=3 and p=4 items take a longer chain of products than norms 0, 1, 2 and infinity,
// all of it through the one 32x32 multiplier
// a last item adds the root bisection on p=2, p=3 and p=4, one root bit per pass,
// and the result is then loaded into the response register
// reset sets norm_mode to 2 and clears the accumulator, count and flags
// req_ch.ready is low while an item is in work or a result waits on a full rsp_ch
module minkowski_distance_accumulator #(
   parameter int MAX_LEN   = 1024,
   parameter int ELEM_BITS = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   mda_req_if.sink                     req_ch,
   mda_rsp_if.source                   rsp_ch,
   input  logic                        csr_wr_en,
   input  logic [mda_pkg::MODE_W-1:0]  csr_wr_data
);
   import mda_pkg::*;

   localparam int CNT_W = $clog2(MAX_LEN + 1);

   state_type             state_ff, state_in;
   logic [MODE_W-1:0]     mode_ff;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   logic [ELEM_BITS-1:0]  diff_ff, diff_in;
   logic                  last_ff, last_in;
   logic [1:0]            step_ff, step_in;
   logic [DIST_W-1:0]     root_ff, root_in;
   logic [BIT_W-1:0]      bit_ff, bit_in;
   logic [ACC_W-1:0]      prod_ff, prod_in;
   logic [ACC_W-1:0]      hold_ff, hold_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]     rsp_dist_ff, rsp_dist_in;
   logic                  rsp_sat_ff, rsp_sat_in;

   logic                  accept;
   logic signed [ELEM_BITS:0] d;
   logic [ELEM_BITS:0]    d_abs;
   logic                  is_root;
   logic [1:0]            term_last;
   logic [1:0]            root_last;
   logic [BIT_W-1:0]      root_top;
   logic [MUL_W-1:0]      mul_a, mul_b;
   logic [DIST_W-1:0]     cand;
   logic [ACC_W:0]        sum;
   logic [ACC_W-1:0]      term;
   logic [ACC_W+2:0]      pw;
   logic                  fits;
   logic [ACC_W-1:0]      dist_src;
   logic                  out_free;

   assign accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.distance = rsp_dist_ff;
   assign rsp_ch.saturated = rsp_sat_ff;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   assign d = {req_ch.elem_a[ELEM_BITS-1], req_ch.elem_a}
            - {req_ch.elem_b[ELEM_BITS-1], req_ch.elem_b};
   assign d_abs = d[ELEM_BITS] ? $unsigned(-d) : $unsigned(d);

   assign is_root = (mode_ff == MODE_TWO) || (mode_ff == MODE_P3) || (mode_ff == MODE_P4);
   assign term_last = ((mode_ff == MODE_P3) || (mode_ff == MODE_P4)) ? 2'd1 : 2'd0;
   assign cand = root_ff | (DIST_W'(1) << bit_ff);
   assign sum = {1'b0, acc_ff} + {1'b0, term};
   assign fits = (pw <= {3'b000, acc_ff});
   assign dist_src = is_root ? {{(ACC_W-DIST_W){1'b0}}, root_ff} : acc_ff;
   assign prod_in = mul_a * mul_b;

   always_comb begin
      unique case (mode_ff)
         MODE_P3: begin
            root_last = 2'd3;
            root_top  = ROOT3_TOP;
         end
         MODE_P4: begin
            root_last = 2'd2;
            root_top  = ROOT4_TOP;
         end
         default: begin
            root_last = 2'd1;
            root_top  = ROOT2_TOP;
         end
      endcase
   end

   always_comb begin
      unique case (mode_ff)
         MODE_ZERO: term = ACC_W'(diff_ff != '0);
         MODE_ONE:  term = ACC_W'(diff_ff);
         default:   term = prod_ff;
      endcase
      if (mode_ff == MODE_P3) begin
         pw = {3'b000, hold_ff} + {prod_ff[34:0], 32'd0};
      end else begin
         pw = {3'b000, prod_ff};
      end
   end

   // multiplier operand select
   always_comb begin
      mul_a = MUL_W'(diff_ff);
      mul_b = MUL_W'(diff_ff);
      if (state_ff == ST_TERM && step_ff != 2'd0) begin
         mul_a = prod_ff[MUL_W-1:0];
         mul_b = (mode_ff == MODE_P4) ? prod_ff[MUL_W-1:0] : MUL_W'(diff_ff);
      end else if (state_ff == ST_ROOT) begin
         unique case (step_ff)
            2'd0: begin
               mul_a = cand;
               mul_b = cand;
            end
            2'd1: begin
               mul_a = prod_ff[MUL_W-1:0];
               mul_b = (mode_ff == MODE_P4) ? prod_ff[MUL_W-1:0] : cand;
            end
            default: begin
               mul_a = hold_ff[ACC_W-1:MUL_W];
               mul_b = cand;
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      diff_in      = diff_ff;
      last_in      = last_ff;
      step_in      = step_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_dist_in  = rsp_dist_ff;
      rsp_sat_in   = rsp_sat_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               diff_in  = d_abs[ELEM_BITS-1:0];
               last_in  = req_ch.last_element;
               step_in  = 2'd0;
               state_in = ST_TERM;
            end
         end
         ST_TERM: begin
            if (step_ff == term_last) begin
               state_in = ST_ACC;
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
         ST_ACC: begin
            if (mode_ff > MODE_P4) begin
               if (ACC_W'(diff_ff) > acc_ff) begin
                  acc_in = ACC_W'(diff_ff);
               end
            end else if (sum[ACC_W]) begin
               acc_in = '1;
               ovf_in = 1'b1;
            end else begin
               acc_in = sum[ACC_W-1:0];
            end
            if (count_ff < CNT_W'(MAX_LEN)) begin
               count_in = count_ff + CNT_W'(1);
            end
            step_in = 2'd0;
            root_in = '0;
            bit_in  = root_top;
            priority if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (is_root) begin
               state_in = ST_ROOT;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_ROOT: begin
            if (step_ff == root_last) begin
               if (fits) begin
                  root_in = cand;
               end
               step_in = 2'd0;
               if (bit_ff == '0) begin
                  state_in = ST_OUT;
               end else begin
                  bit_in = bit_ff - BIT_W'(1);
               end
            end else begin
               step_in = step_ff + 2'd1;
               if (step_ff != 2'd0) begin
                  hold_in = prod_ff;
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sat_in   = ovf_ff || (|dist_src[ACC_W-1:DIST_W]);
               rsp_dist_in  = (|dist_src[ACC_W-1:DIST_W]) ? '1 : dist_src[DIST_W-1:0];
               acc_in       = '0;
               count_in     = '0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_TWO;
         acc_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         step_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      diff_ff     <= diff_in;
      last_ff     <= last_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      prod_ff     <= prod_in;
      hold_ff     <= hold_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

endmodule

// ----- src/mda_checker.sv -----
// port-level checker for the minkowski distance accumulator, with its bind
// depends on mda_pkg and minkowski_distance_accumulator_assert.svh
`include "minkowski_distance_accumulator_assert.svh"

module mda_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_last,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [mda_pkg::DIST_W-1:0]  rsp_distance,
   input logic                        rsp_saturated
);
   import mda_pkg::*;

   logic [DIST_W-1:0] dist_seen;
   assign dist_seen = rsp_distance;

   // stalled response holds
   `MDA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(dist_seen) && $stable(rsp_saturated), "stalled response changed")

   // an accepted item keeps the block busy
   `MDA_ASSERT(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready, "ready right after an accepted item")

   // a non-last item never raises a result next cycle
   `MDA_ASSERT(a_no_early_rsp, clock, reset, req_valid && req_ready && !req_last && !rsp_valid |=> !rsp_valid, "result appeared after a non-last item")

   // reset empties the response register
   `MDA_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind minkowski_distance_accumulator mda_checker u_mda_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_last      (req_ch.last_element),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_distance  (rsp_ch.distance),
   .rsp_saturated (rsp_ch.saturated)
);

// ----- dv/tb_minkowski_distance_accumulator.sv -----
// self-checking testbench for minkowski_distance_accumulator: a directed table,
// one vector past MAX_LEN and random vectors, checked against pinned rows or an in-bench model
// depends on mda_pkg, mda_channels and the block itself
module tb_minkowski_distance_accumulator;
   timeunit 1ns;
   timeprecision 1ps;
   import mda_pkg::*;

   localparam int MAX_LEN       = 1024;
   localparam int ELEM_BITS     = 12;
   localparam int RAND_ITEMS    = 900;
   localparam int CALM_TAIL     = 300;
   localparam int SETTLE_CYCLES = 120;
   localparam int LONG_LEN      = 1100;
   localparam int HOLD_CYCLES   = 500;
   localparam int ROWS          = 24;

   localparam logic [MODE_W-1:0] NORM_INF    = 3'd5;
   localparam logic [MODE_W-1:0] NORM_SPARE6 = 3'd6;
   localparam logic [MODE_W-1:0] NORM_SPARE7 = 3'd7;

   localparam logic signed [ELEM_BITS-1:0] E_MIN = 12'h800;
   localparam logic signed [ELEM_BITS-1:0] E_MAX = 12'h7FF;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              saturated;
   } dist_res_type;

   typedef struct packed {
      logic [MODE_W-1:0]           mode;
      logic signed [ELEM_BITS-1:0] a;
      logic signed [ELEM_BITS-1:0] b;
      logic                        last;
      logic                        pinned;
      logic [DIST_W-1:0]           distance;
      logic                        saturated;
   } step_row_type;

   localparam step_row_type SCRIPT [ROWS] = '{
      '{MODE_TWO,    E_MAX,       E_MIN,         1'b1, 1'b1, 32'd4095, 1'b0},
      '{MODE_TWO,    E_MIN,       E_MAX,         1'b1, 1'b1, 32'd4095, 1'b0},
      '{MODE_TWO,    12'sd0,      12'sd0,        1'b1, 1'b1, 32'd0,    1'b0},
      '{MODE_TWO,    12'sd3,      12'sd0,        1'b0, 1'b0, 32'd0,    1'b0},
      '{MODE_TWO,    12'sd0,      12'sd4,        1'b1, 1'b1, 32'd5,    1'b0},
      '{MODE_ZERO,   12'sd5,      12'sd5,        1'b0, 1'b0, 32'd0,    1'b0},
      '{MODE_ZERO,   E_MAX,       E_MIN,         1'b0, 1'b0, 32'd0,    1'b0},
      '{MODE_ZERO,   -12'sd1,     12'sd1,        1'b1, 1'b1, 32'd2,    1'b0},
      '{MODE_ONE,    E_MAX,       E_MIN,         1'b0, 1'b0, 32'd0,    1'b0},
      '{MODE_ONE,    E_MIN,       E_MAX,         1'b1, 1'b1, 32'd8190, 1'b0},
      '{MODE_P3,     E_MAX,       E_MIN,         1'b1, 1'b1, 32'd4095, 1'b0},
      '{MODE_P4,     E_MIN,       E_MAX,         1'b1, 1'b1, 32'd4095, 1'b0},
      '{MODE_P3,     12'sd1,      12'sd0,        1'b0, 1'b0, 32'd0,    1'b0},
      '{MODE_P3,     12'sd1,      12'sd0,        1'b1, 1'b0, 32'd0,    1'b0},
      '{MODE_P4,     12'sd2,      12'sd0,        1'b0, 1'b0, 32'd0,    1'b0},
      '{MODE_P4,     12'sd0,      12'sd3,        1'b1, 1'b0, 32'd0,    1'b0},
      '{NORM_INF,    12'sd3,      -12'sd4,       1'b0, 1'b0, 32'd0,    1'b0},
      '{NORM_INF,    12'sd0,      12'sd0,        1'b0, 1'b0, 32'd0,    1'b0},
      '{NORM_INF,    12'sd100,    -12'sd100,     1'b1, 1'b1, 32'd200,  1'b0},
      '{NORM_SPARE6, 12'sd1,      12'sd2,        1'b1, 1'b1, 32'd1,    1'b0},
      '{NORM_SPARE7, E_MIN,       E_MIN,         1'b0, 1'b0, 32'd0,    1'b0},
      '{NORM_SPARE7, 12'sd10,     12'sd0,        1'b1, 1'b1, 32'd10,   1'b0},
      '{MODE_ONE,    12'sd3,      12'sd0,        1'b0, 1'b0, 32'd0,    1'b0},
      '{MODE_TWO,    12'sd4,      12'sd0,        1'b1, 1'b0, 32'd0,    1'b0}
   };

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [MODE_W-1:0] csr_wr_data;

   // model state
   logic [ACC_W-1:0]  acc_sum;
   logic              acc_sat;
   logic [14:0]       elem_cnt;
   logic [MODE_W-1:0] norm_sel;

   dist_res_type dist_q [$];
   int          err_cnt = 0;
   int unsigned rsp_seen = 0;
   bit          calm = 1'b0;
   bit          cfg_busy = 1'b0;
   bit          hold_on = 1'b0;

   mda_req_if #(.ELEM_BITS(ELEM_BITS)) req_bus ();
   mda_rsp_if rsp_bus ();

   minkowski_distance_accumulator #(
      .MAX_LEN  (MAX_LEN),
      .ELEM_BITS(ELEM_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_bus),
      .rsp_ch     (rsp_bus),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic flag_mismatch(input string what, input longint unsigned got,
                                input longint unsigned want);
      $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
      err_cnt++;
   endtask

   function automatic logic [31:0] int_root(input logic [ACC_W-1:0] v, input int unsigned k);
      logic [31:0]  r;
      logic [31:0]  cand;
      logic [127:0] p;
      r = '0;
      for (int bit_i = 31; bit_i >= 0; bit_i--) begin
         cand = r | (32'd1 << bit_i);
         p = 128'd1;
         for (int j = 0; j < k; j++) p = p * 128'(cand);
         if (p <= {64'd0, v}) r = cand;
      end
      return r;
   endfunction

   task automatic accumulate_elem(input logic signed [ELEM_BITS-1:0] a,
                                  input logic signed [ELEM_BITS-1:0] b,
                                  input logic last, output logic emits,
                                  output dist_res_type res);
      logic signed [ELEM_BITS:0] d;
      logic [ACC_W-1:0]          mag;
      logic [ACC_W-1:0]          term;
      logic [ACC_W-1:0]          root;
      logic [ACC_W:0]            wide;
      d = 13'(a) - 13'(b);
      mag = d[ELEM_BITS] ? 64'(-d) : 64'(d);
      case (norm_sel)
         MODE_ZERO: term = (mag != 0) ? 64'd1 : 64'd0;
         MODE_ONE:  term = mag;
         MODE_TWO:  term = mag * mag;
         MODE_P3:   term = mag * mag * mag;
         MODE_P4:   term = mag * mag * mag * mag;
         default:   term = '0;
      endcase
      if (norm_sel <= MODE_P4) begin
         wide = {1'b0, acc_sum} + {1'b0, term};
         if (wide[ACC_W]) begin
            acc_sum = '1;
            acc_sat = 1'b1;
         end else begin
            acc_sum = wide[ACC_W-1:0];
         end
      end else if (mag > acc_sum) begin
         acc_sum = mag;
      end
      if (elem_cnt < MAX_LEN) elem_cnt++;
      emits = last;
      res = '0;
      if (last) begin
         case (norm_sel)
            MODE_TWO: root = 64'(int_root(acc_sum, 2));
            MODE_P3:  root = 64'(int_root(acc_sum, 3));
            MODE_P4:  root = 64'(int_root(acc_sum, 4));
            default:  root = acc_sum;
         endcase
         res.saturated = acc_sat;
         if (root > 64'hFFFF_FFFF) begin
            res.distance  = '1;
            res.saturated = 1'b1;
         end else begin
            res.distance = root[DIST_W-1:0];
         end
         acc_sum  = '0;
         acc_sat  = 1'b0;
         elem_cnt = '0;
      end
   endtask

   task automatic set_norm(input logic [MODE_W-1:0] m);
      cfg_busy = 1'b1;
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (dist_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      norm_sel = m;
      cfg_busy = 1'b0;
   endtask

   task automatic send_elem(input logic signed [ELEM_BITS-1:0] a,
                            input logic signed [ELEM_BITS-1:0] b,
                            input logic last, input logic pinned,
                            input dist_res_type pinned_res);
      int unsigned gap;
      logic        emits;
      dist_res_type got;
      @(negedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.elem_a       <= a;
      req_bus.elem_b       <= b;
      req_bus.last_element <= last;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      accumulate_elem(a, b, last, emits, got);
      if (emits) dist_q.push_back(pinned ? pinned_res : got);
   endtask

   function automatic logic signed [ELEM_BITS-1:0] pick_elem();
      case ($urandom_range(0, 5))
         0:       return E_MIN;
         1:       return E_MAX;
         2:       return 12'($urandom_range(0, 15)) - 12'd8;
         default: return 12'($urandom_range(0, 4095));
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin : rsp_check
      dist_res_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (dist_q.size() == 0) begin
            flag_mismatch("result with none expected", rsp_bus.distance, 0);
         end else begin
            want = dist_q.pop_front();
            if (rsp_bus.distance !== want.distance)
               flag_mismatch("distance", rsp_bus.distance, want.distance);
            if (rsp_bus.saturated !== want.saturated)
               flag_mismatch("saturated", rsp_bus.saturated, want.saturated);
         end
         rsp_seen++;
      end
   end

   // result side backpressure, with one long hold to fill the block
   initial begin : rsp_side
      int unsigned burst;
      bit          held;
      rsp_bus.ready = 1'b0;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && rsp_seen >= 40 && !cfg_busy) begin
            held = 1'b1;
            hold_on = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_on = 1'b0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            burst = $urandom_range(1, 18);
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int          sent;
      int          len;
      logic signed [ELEM_BITS-1:0] ea;
      logic signed [ELEM_BITS-1:0] eb;
      dist_res_type pin;
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      req_bus.valid        = 1'b0;
      req_bus.elem_a       = '0;
      req_bus.elem_b       = '0;
      req_bus.last_element = 1'b0;
      acc_sum  = '0;
      acc_sat  = 1'b0;
      elem_cnt = '0;
      norm_sel = MODE_TWO;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table, first rows run on the reset norm
      for (int i = 0; i < ROWS; i++) begin
         if (SCRIPT[i].mode != norm_sel) set_norm(SCRIPT[i].mode);
         pin.distance  = SCRIPT[i].distance;
         pin.saturated = SCRIPT[i].saturated;
         send_elem(SCRIPT[i].a, SCRIPT[i].b, SCRIPT[i].last, SCRIPT[i].pinned, pin);
      end

      // one vector past MAX_LEN on the p=4 norm
      calm = 1'b1;
      set_norm(MODE_P4);
      pin = '0;
      for (int i = 0; i < LONG_LEN; i++)
         send_elem(E_MAX, E_MIN, i == LONG_LEN - 1, 1'b0, pin);
      calm = 1'b0;

      sent = 0;
      while (sent < RAND_ITEMS) begin
         if (!hold_on && $urandom_range(0, 2) == 0) set_norm(3'($urandom_range(0, 7)));
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         for (int k = 0; k < len; k++) begin
            if (!hold_on && k > 0 && $urandom_range(0, 39) == 0)
               set_norm(3'($urandom_range(0, 7)));
            ea = pick_elem();
            eb = ($urandom_range(0, 5) == 0) ? ea : pick_elem();
            calm = (sent >= RAND_ITEMS - CALM_TAIL);
            send_elem(ea, eb, k == len - 1, 1'b0, pin);
            sent++;
         end
      end

      calm = 1'b1;
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (dist_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (err_cnt == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
